// ===== rtl/dyp_pkg.sv =====
// Shared constants, types and the arctangent table for the direction-to-angles block.
package dyp_pkg;

   // Defaults for the top-level parameters
   localparam int COMPONENT_WIDTH_DEF     = 16;
   localparam int ANGLE_FRACTION_BITS_DEF = 6;
   localparam int CORDIC_STAGES_DEF       = 16;

   // Fixed arithmetic settings
   localparam int GUARD_BITS = 8;
   localparam int ACC_FRAC   = 20;
   localparam int ACC_WIDTH  = 28;
   localparam int TABLE_LEN  = 24;
   localparam int GAIN_WIDTH = 31;
   localparam int GAIN_SHIFT = 22;
   localparam logic [GAIN_WIDTH-1:0] GAIN_Q30 = 31'd1768195363;

   // Quadrant and special-case flags carried beside the datapath
   typedef struct packed {
      logic x_neg;
      logic z_neg;
      logic y_neg;
      logic y_pos;
      logic vertical;
   } flags_type;

   // atan(2^-i) in degrees, Q20
   function automatic logic signed [ACC_WIDTH-1:0] atan_q20(input int idx);
      logic signed [ACC_WIDTH-1:0] val;
      unique case (idx)
         0:       val = 28'sd47185920;
         1:       val = 28'sd27855475;
         2:       val = 28'sd14718068;
         3:       val = 28'sd7471121;
         4:       val = 28'sd3750058;
         5:       val = 28'sd1876857;
         6:       val = 28'sd938658;
         7:       val = 28'sd469357;
         8:       val = 28'sd234682;
         9:       val = 28'sd117342;
         10:      val = 28'sd58671;
         11:      val = 28'sd29335;
         12:      val = 28'sd14668;
         13:      val = 28'sd7334;
         14:      val = 28'sd3667;
         15:      val = 28'sd1833;
         16:      val = 28'sd917;
         17:      val = 28'sd458;
         18:      val = 28'sd229;
         19:      val = 28'sd115;
         20:      val = 28'sd57;
         21:      val = 28'sd29;
         22:      val = 28'sd14;
         23:      val = 28'sd7;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/dyp_cell.sv =====
// One vectoring CORDIC cell: a single micro-rotation with its pipeline register.
module dyp_cell #(
   parameter int W     = 28,
   parameter int AW    = dyp_pkg::ACC_WIDTH,
   parameter int PW    = 8,
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic signed [W-1:0]  in_px,
   input  logic signed [W-1:0]  in_py,
   input  logic signed [AW-1:0] in_acc,
   input  logic [PW-1:0]        in_pay,
   output logic                 out_valid,
   output logic signed [W-1:0]  out_px,
   output logic signed [W-1:0]  out_py,
   output logic signed [AW-1:0] out_acc,
   output logic [PW-1:0]        out_pay
);

   logic                 valid_ff;
   logic signed [W-1:0]  px_ff, px_in, py_ff, py_in, dx, dy;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic [PW-1:0]        pay_ff;
   logic                 rot_pos;

   always_comb begin
      dx      = in_py >>> STAGE;
      dy      = in_px >>> STAGE;
      rot_pos = !in_py[W-1] && (in_py != '0);
      if (rot_pos) begin
         px_in  = in_px + dx;
         py_in  = in_py - dy;
         acc_in = in_acc + dyp_pkg::atan_q20(STAGE);
      end else begin
         px_in  = in_px - dx;
         py_in  = in_py + dy;
         acc_in = in_acc - dyp_pkg::atan_q20(STAGE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff  <= px_in;
         py_ff  <= py_in;
         acc_ff <= acc_in;
         pay_ff <= in_pay;
      end
   end

   assign out_valid = valid_ff;
   assign out_px    = px_ff;
   assign out_py    = py_ff;
   assign out_acc   = acc_ff;
   assign out_pay   = pay_ff;

endmodule

// ===== rtl/direction_to_yaw_pitch.sv =====
// Top level: 3D direction vector to yaw and pitch through two chained CORDIC cell rows.
// Registers from item accept to result valid: stage A, stage B, pass 1 cells, pass 2 cells, output.
// Throughput: one item per cycle unless stalled; single-rotation cells, one per stage.
// Stall: the whole pipeline freezes while a result waits and rsp_stall is high.
// Reset: synchronous, active high; clears every valid bit, no result is shown after it.
// Payload registers are not reset.
module direction_to_yaw_pitch #(
   parameter int COMPONENT_WIDTH     = dyp_pkg::COMPONENT_WIDTH_DEF,
   parameter int ANGLE_FRACTION_BITS = dyp_pkg::ANGLE_FRACTION_BITS_DEF,
   parameter int CORDIC_STAGES       = dyp_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [COMPONENT_WIDTH-1:0]    req_x_component,
   input  logic signed [COMPONENT_WIDTH-1:0]    req_y_component,
   input  logic signed [COMPONENT_WIDTH-1:0]    req_z_component,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [9+ANGLE_FRACTION_BITS-1:0]     rsp_yaw_angle,
   output logic signed [8+ANGLE_FRACTION_BITS-1:0] rsp_pitch_angle
);

   localparam int CW   = COMPONENT_WIDTH;
   localparam int AF   = ANGLE_FRACTION_BITS;
   localparam int N    = CORDIC_STAGES;
   localparam int W    = CW + 12;                  // datapath, covers growth of both passes
   localparam int AW   = dyp_pkg::ACC_WIDTH;
   localparam int FW   = $bits(dyp_pkg::flags_type);
   localparam int P1W  = W + FW;                   // pass 1 carries scaled |y| and flags
   localparam int P2W  = AW + FW;                  // pass 2 carries yaw angle and flags
   localparam int PRW  = CW + 1 + dyp_pkg::GAIN_WIDTH;
   localparam int YW   = 30;                       // unsigned Q20 full-turn angle
   localparam int YAWW = 9 + AF;
   localparam int PITW = 8 + AF;
   localparam int RS   = dyp_pkg::ACC_FRAC - AF;   // rounding shift

   localparam logic [YW-1:0]  DEG90_Q   = YW'(90) << dyp_pkg::ACC_FRAC;
   localparam logic [YW-1:0]  DEG180_Q  = YW'(180) << dyp_pkg::ACC_FRAC;
   localparam logic [YW-1:0]  DEG360_Q  = YW'(360) << dyp_pkg::ACC_FRAC;
   localparam logic [YW-1:0]  RND_HALF  = YW'(1) << (RS - 1);
   localparam logic [YW-1:0]  TURN_OUT  = YW'(360) << AF;
   localparam logic [YW-1:0]  FULL90    = YW'(90) << AF;
   localparam logic [PRW-1:0] GAIN_HALF = PRW'(1) << (dyp_pkg::GAIN_SHIFT - 1);

   // Pipeline moves as one whenever the output register is free or being taken.
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // ---- Stage A: capture the raw item
   logic                 a_valid_ff;
   logic signed [CW-1:0] a_x_ff, a_y_ff, a_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_x_ff <= req_x_component;
         a_y_ff <= req_y_component;
         a_z_ff <= req_z_component;
      end
   end

   // ---- Stage B: magnitudes, gain-scaled |y|, quadrant flags
   logic [CW:0]          ax, ay, az;
   logic [PRW-1:0]       y_prod;
   logic [W-1:0]         ys_in, px0_in, py0_in;
   dyp_pkg::flags_type   flags_in;

   logic                 b_valid_ff;
   logic [W-1:0]         b_px_ff, b_py_ff, b_ys_ff;
   dyp_pkg::flags_type   b_flags_ff;

   always_comb begin
      ax = a_x_ff[CW-1] ? (~{1'b1, a_x_ff} + 1'b1) : {1'b0, a_x_ff};
      ay = a_y_ff[CW-1] ? (~{1'b1, a_y_ff} + 1'b1) : {1'b0, a_y_ff};
      az = a_z_ff[CW-1] ? (~{1'b1, a_z_ff} + 1'b1) : {1'b0, a_z_ff};
      // |y| * K, rounded back to the guard-bit scale of the horizontal length
      y_prod = PRW'(ay) * PRW'(dyp_pkg::GAIN_Q30);
      ys_in  = W'((y_prod + GAIN_HALF) >> dyp_pkg::GAIN_SHIFT);
      px0_in = W'(az) << dyp_pkg::GUARD_BITS;
      py0_in = W'(ax) << dyp_pkg::GUARD_BITS;
      flags_in.x_neg    = a_x_ff[CW-1];
      flags_in.z_neg    = a_z_ff[CW-1];
      flags_in.y_neg    = a_y_ff[CW-1];
      flags_in.y_pos    = !a_y_ff[CW-1] && (a_y_ff != '0);
      flags_in.vertical = (a_x_ff == '0) && (a_z_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_px_ff    <= px0_in;
         b_py_ff    <= py0_in;
         b_ys_ff    <= ys_in;
         b_flags_ff <= flags_in;
      end
   end

   // ---- Pass 1: yaw in the first quadrant and gain-scaled horizontal length
   logic                 c1_valid [0:N];
   logic signed [W-1:0]  c1_px    [0:N];
   logic signed [W-1:0]  c1_py    [0:N];
   logic signed [AW-1:0] c1_acc   [0:N];
   logic [P1W-1:0]       c1_pay   [0:N];

   assign c1_valid[0] = b_valid_ff;
   assign c1_px[0]    = b_px_ff;
   assign c1_py[0]    = b_py_ff;
   assign c1_acc[0]   = '0;
   assign c1_pay[0]   = {b_ys_ff, b_flags_ff};

   // ---- Pass 2: pitch magnitude from (horizontal length, scaled |y|)
   logic                 c2_valid [0:N];
   logic signed [W-1:0]  c2_px    [0:N];
   logic signed [W-1:0]  c2_py    [0:N];
   logic signed [AW-1:0] c2_acc   [0:N];
   logic [P2W-1:0]       c2_pay   [0:N];

   assign c2_valid[0] = c1_valid[N];
   assign c2_px[0]    = c1_px[N];
   assign c2_py[0]    = c1_pay[N][P1W-1:FW];
   assign c2_acc[0]   = '0;
   assign c2_pay[0]   = {c1_acc[N], c1_pay[N][FW-1:0]};

   for (genvar i = 0; i < N; i++) begin : g_cells
      dyp_cell #(.W(W), .AW(AW), .PW(P1W), .STAGE(i)) u_yaw_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (c1_valid[i]),
         .in_px    (c1_px[i]),
         .in_py    (c1_py[i]),
         .in_acc   (c1_acc[i]),
         .in_pay   (c1_pay[i]),
         .out_valid(c1_valid[i+1]),
         .out_px   (c1_px[i+1]),
         .out_py   (c1_py[i+1]),
         .out_acc  (c1_acc[i+1]),
         .out_pay  (c1_pay[i+1])
      );
      dyp_cell #(.W(W), .AW(AW), .PW(P2W), .STAGE(i)) u_pitch_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (c2_valid[i]),
         .in_px    (c2_px[i]),
         .in_py    (c2_py[i]),
         .in_acc   (c2_acc[i]),
         .in_pay   (c2_pay[i]),
         .out_valid(c2_valid[i+1]),
         .out_px   (c2_px[i+1]),
         .out_py   (c2_py[i+1]),
         .out_acc  (c2_acc[i+1]),
         .out_pay  (c2_pay[i+1])
      );
   end

   // ---- Output stage: clamp, map quadrant, round, handle the vertical case
   dyp_pkg::flags_type   fl;
   logic signed [AW-1:0] yaw_acc;
   logic [YW-1:0]        a1, pa, yq, yaw_r, pitch_r;
   logic [YAWW-1:0]      yaw_in;
   logic signed [PITW-1:0] pitch_in;

   always_comb begin
      fl      = c2_pay[N][FW-1:0];
      yaw_acc = c2_pay[N][P2W-1:FW];

      // clamp each pass angle to [0, 90] degrees
      if (yaw_acc[AW-1]) begin
         a1 = '0;
      end else if (YW'(yaw_acc) > DEG90_Q) begin
         a1 = DEG90_Q;
      end else begin
         a1 = YW'(yaw_acc);
      end
      if (c2_acc[N][AW-1]) begin
         pa = '0;
      end else if (YW'(c2_acc[N]) > DEG90_Q) begin
         pa = DEG90_Q;
      end else begin
         pa = YW'(c2_acc[N]);
      end

      // fold the first-quadrant angle into the full turn
      if (!fl.x_neg) begin
         yq = fl.z_neg ? (DEG180_Q - a1) : a1;
      end else begin
         yq = fl.z_neg ? (DEG180_Q + a1) : (DEG360_Q - a1);
      end

      yaw_r   = (yq + RND_HALF) >> RS;
      pitch_r = (pa + RND_HALF) >> RS;
      if (yaw_r >= TURN_OUT) begin
         yaw_r = '0;
      end
      if (pitch_r > FULL90) begin
         pitch_r = FULL90;
      end

      if (fl.vertical) begin
         yaw_in = '0;
         if (fl.y_pos) begin
            pitch_in = PITW'(FULL90);
         end else if (fl.y_neg) begin
            pitch_in = -PITW'(FULL90);
         end else begin
            pitch_in = '0;
         end
      end else begin
         yaw_in   = YAWW'(yaw_r);
         pitch_in = fl.y_neg ? -PITW'(pitch_r) : PITW'(pitch_r);
      end
   end

   logic                   rsp_valid_ff;
   logic [YAWW-1:0]        rsp_yaw_ff;
   logic signed [PITW-1:0] rsp_pitch_ff;

   // Output register: hold while stalled, load on advance
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= c2_valid[N];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_yaw_ff   <= yaw_in;
         rsp_pitch_ff <= pitch_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_yaw_angle   = rsp_yaw_ff;
   assign rsp_pitch_angle = rsp_pitch_ff;

endmodule

// ===== rtl/dyp_checker.sv =====
// Port-level checker for the direction-to-angles block, bound to the top level.
module dyp_checker #(
   parameter int ANGLE_FRACTION_BITS = dyp_pkg::ANGLE_FRACTION_BITS_DEF
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic [9+ANGLE_FRACTION_BITS-1:0]       rsp_yaw_angle,
   input logic signed [8+ANGLE_FRACTION_BITS-1:0] rsp_pitch_angle
);

   localparam int YAWW = 9 + ANGLE_FRACTION_BITS;
   localparam int PITW = 8 + ANGLE_FRACTION_BITS;
   localparam logic [YAWW-1:0]        TURN   = YAWW'(360) << ANGLE_FRACTION_BITS;
   localparam logic signed [PITW-1:0] P90    = PITW'(90) << ANGLE_FRACTION_BITS;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while output free");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_yaw_angle)
                                    && $stable(rsp_pitch_angle)))
      else $error("stalled result changed");

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_yaw_angle < TURN))
      else $error("yaw out of range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_pitch_angle <= P90) && (rsp_pitch_angle >= -P90)))
      else $error("pitch out of range");

endmodule

bind direction_to_yaw_pitch dyp_checker #(
   .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
) u_dyp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_yaw_angle  (rsp_yaw_angle),
   .rsp_pitch_angle(rsp_pitch_angle)
);
